@@ rtl/radix_prefixed_number_parser_unit_macros.svh @@
// Assertion macros used by the checker file of the number parser.
`ifndef RADIX_PREFIXED_NUMBER_PARSER_UNIT_MACROS_SVH
`define RADIX_PREFIXED_NUMBER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, inactive while reset is held.
`define RPNP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpnp assertion failed");

// Next-cycle implication, inactive while reset is held.
`define RPNP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpnp assertion failed");

// Next-cycle implication that also holds across reset.
`define RPNP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rpnp reset assertion failed");

`endif

@@ rtl/rpnp_pkg.sv @@
// Package with types and constants of the radix-prefixed number parser.
`timescale 1ns / 1ps
`default_nettype none
package rpnp_pkg;

    // Default depth of the queue between the classifier and the parser.
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

    // Parser phase within one number string.
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SIGN  = 2'd1,
        PH_ZERO  = 2'd2,
        PH_DIGIT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_NEG  = 2'd1,
        ADJ_NOT  = 2'd2
    } t_adjust;

    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2
    } t_radix;

    // Classified character as it travels through the queue.
    typedef struct packed {
        logic       is_end;
        logic       is_minus;
        logic       is_tilde;
        logic       is_zero;
        logic       is_x;
        logic       is_hex_digit;
        logic [3:0] digit;
    } t_class;

endpackage
`default_nettype wire

@@ rtl/rpnp_front.sv @@
// Front end: takes characters and classifies them for the parser.
`timescale 1ns / 1ps
`default_nettype none
module rpnp_front (
    input  wire logic                       i_valid,
    input  wire logic [rpnp_pkg::CHAR_W-1:0] i_ch,
    input  wire logic                       i_end,
    input  wire logic                       i_queue_full,
    output logic                            o_ready,
    output logic                            o_push,
    output rpnp_pkg::t_class                o_entry
);
    import rpnp_pkg::*;

    logic [CHAR_W-1:0] w_off_num;
    logic [CHAR_W-1:0] w_off_lo;
    logic [CHAR_W-1:0] w_off_up;

    // A request is taken whenever the queue has room.
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    assign w_off_num = i_ch - CH_ZERO;
    assign w_off_lo  = i_ch - CH_LO_A + 8'd10;
    assign w_off_up  = i_ch - CH_UP_A + 8'd10;

    // Decode the character into its role and its digit value.
    always_comb begin
        o_entry          = '0;
        o_entry.is_end   = i_end;
        o_entry.is_minus = (i_ch == CH_MINUS);
        o_entry.is_tilde = (i_ch == CH_TILDE);
        o_entry.is_zero  = (i_ch == CH_ZERO);
        o_entry.is_x     = (i_ch == CH_LO_X) || (i_ch == CH_UP_X);
        if (i_ch inside {[CH_ZERO:CH_NINE]}) begin
            o_entry.is_hex_digit = 1'b1;
            o_entry.digit        = w_off_num[3:0];
        end else if (i_ch inside {[CH_LO_A:CH_LO_F]}) begin
            o_entry.is_hex_digit = 1'b1;
            o_entry.digit        = w_off_lo[3:0];
        end else if (i_ch inside {[CH_UP_A:CH_UP_F]}) begin
            o_entry.is_hex_digit = 1'b1;
            o_entry.digit        = w_off_up[3:0];
        end
    end

endmodule
`default_nettype wire

@@ rtl/rpnp_queue.sv @@
// Short queue of classified characters between front end and parser.
`timescale 1ns / 1ps
`default_nettype none
module rpnp_queue #(
    parameter int DEPTH = rpnp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  rpnp_pkg::t_class      i_entry,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output rpnp_pkg::t_class      o_entry
);
    import rpnp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_class           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_valid   = (r_count != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and count updates, with wrap at the last slot.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rpnp_back.sv @@
// Back end: parser state machine, accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none
module rpnp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  rpnp_pkg::t_class                   i_entry,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [rpnp_pkg::VALUE_W-1:0]       o_value,
    output logic                               o_error
);
    import rpnp_pkg::*;

    t_phase              r_phase;
    t_phase              n_phase;
    t_adjust             r_adjust;
    t_adjust             n_adjust;
    t_radix              r_radix;
    t_radix              n_radix;
    logic [VALUE_W-1:0]  r_accum;
    logic [VALUE_W-1:0]  n_accum;
    logic                r_err;
    logic                n_err;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_error;

    logic                w_take;
    logic                w_char;
    logic                w_sign_hit;
    logic                w_zero_hit;
    logic                w_x_hit;
    logic                w_digit_ok;
    logic [VALUE_W-1:0]  w_scaled;
    logic [VALUE_W-1:0]  w_adjusted;

    // An end marker waits while the result register holds a result that is not taken.
    assign w_take = i_valid && (!i_entry.is_end || !r_out_valid || i_ready);
    assign o_pop  = w_take;
    assign w_char = w_take && !i_entry.is_end && !r_err;

    // Leading sign, leading zero and hex prefix detection.
    assign w_sign_hit = (r_phase == PH_START) && (i_entry.is_minus || i_entry.is_tilde);
    assign w_zero_hit = !w_sign_hit && i_entry.is_zero
                        && ((r_phase == PH_START) || (r_phase == PH_SIGN));
    assign w_x_hit    = (r_phase == PH_ZERO) && i_entry.is_x;

    // Digit check against the current radix.
    always_comb begin
        case (r_radix)
            RAD_HEX: w_digit_ok = i_entry.is_hex_digit;
            RAD_OCT: w_digit_ok = i_entry.is_hex_digit && (i_entry.digit < 4'd8);
            default: w_digit_ok = i_entry.is_hex_digit && (i_entry.digit < 4'd10);
        endcase
    end

    // Accumulator times radix, built from shifts.
    always_comb begin
        case (r_radix)
            RAD_HEX: w_scaled = r_accum << 4;
            RAD_OCT: w_scaled = r_accum << 3;
            default: w_scaled = (r_accum << 3) + (r_accum << 1);
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_take && i_entry.is_end) begin
            n_phase = PH_START;
        end else if (w_char) begin
            if (w_sign_hit) begin
                n_phase = PH_SIGN;
            end else if (w_zero_hit) begin
                n_phase = PH_ZERO;
            end else if (w_x_hit || w_digit_ok) begin
                n_phase = PH_DIGIT;
            end
        end
    end

    // Adjust mode, radix, accumulator and sticky error.
    always_comb begin
        n_adjust = r_adjust;
        n_radix  = r_radix;
        n_accum  = r_accum;
        n_err    = r_err;
        if (w_take && i_entry.is_end) begin
            n_adjust = ADJ_NONE;
            n_radix  = RAD_DEC;
            n_accum  = '0;
            n_err    = 1'b0;
        end else if (w_char) begin
            if (w_sign_hit) begin
                n_adjust = i_entry.is_minus ? ADJ_NEG : ADJ_NOT;
            end else if (w_zero_hit) begin
                n_radix = RAD_OCT;
            end else if (w_x_hit) begin
                n_radix = RAD_HEX;
            end else if (w_digit_ok) begin
                n_accum = w_scaled + {{(VALUE_W-4){1'b0}}, i_entry.digit};
            end else begin
                n_err = 1'b1;
            end
        end
    end

    // Final value after negate or complement.
    always_comb begin
        case (r_adjust)
            ADJ_NEG: w_adjusted = '0 - r_accum;
            ADJ_NOT: w_adjusted = ~r_accum;
            default: w_adjusted = r_accum;
        endcase
    end

    // The result register stays valid until the consumer takes it.
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (w_take && i_entry.is_end) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_adjust    <= ADJ_NONE;
            r_radix     <= RAD_DEC;
            r_accum     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_adjust    <= n_adjust;
            r_radix     <= n_radix;
            r_accum     <= n_accum;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded on an end marker.
    always_ff @(posedge i_clk) begin
        if (w_take && i_entry.is_end) begin
            r_out_value <= r_err ? '0 : w_adjusted;
            r_out_error <= r_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_error;

endmodule
`default_nettype wire

@@ rtl/radix_prefixed_number_parser_unit.sv @@
// Top level of the radix-prefixed number parser.
// An end marker is registered in the queue and then in the result register before m_axis_tvalid rises.
// Throughput: one character per cycle, while the queue has room and no end marker waits.
// An end marker waits in the queue while the result register holds a result not taken.
// Reset is synchronous and active low; it empties the queue, clears the parser
// state and drops m_axis_tvalid. The result payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module radix_prefixed_number_parser_unit #(
    parameter int QUEUE_DEPTH = rpnp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] ch
    input  wire logic                        s_axis_tlast,  // is_end
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [rpnp_pkg::VALUE_W-1:0]     m_axis_tdata,  // [63:0] value
    output logic                             m_axis_tuser   // [0] error
);
    import rpnp_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_q_valid;
    t_class w_push_entry;
    t_class w_q_entry;

    rpnp_front u_front (
        .i_valid      (s_axis_tvalid),
        .i_ch         (s_axis_tdata),
        .i_end        (s_axis_tlast),
        .i_queue_full (w_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    rpnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    rpnp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_entry (w_q_entry),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (m_axis_tdata),
        .o_error (m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ rtl/rpnp_checker.sv @@
// Port-level checker for the number parser and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "radix_prefixed_number_parser_unit_macros.svh"
module rpnp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    logic w_stall;

    // A result is offered but not taken in this cycle.
    assign w_stall = m_axis_tvalid && !m_axis_tready;

    // A pending result is not withdrawn.
    `RPNP_ASSERT_NXT(a_out_hold, w_stall, m_axis_tvalid)

    // A stalled result keeps its payload.
    `RPNP_ASSERT_NXT(a_out_stable, w_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // An error result carries a zero value.
    `RPNP_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0)

    // Reset leaves no result pending and an empty queue.
    `RPNP_ASSERT_RST(a_reset_idle, !i_rst_n, !m_axis_tvalid && s_axis_tready)

endmodule

bind radix_prefixed_number_parser_unit rpnp_checker u_checker (.*);
`default_nettype wire
